### design/csp_pkg.sv
// Package for the alignment op string parser: request and response types,
// character codes, op and error codes, and the op letter decoder. No dependencies.
`default_nettype none
package csp_pkg;

   localparam int CSP_MAX_DIGITS = 10;
   localparam logic [5:0] CSP_MAX_OPS_RESET = 6'd50;

   localparam logic [7:0] CHAR_NUL      = 8'h00;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_EQUAL    = 8'h3D;
   localparam logic [7:0] CHAR_MISMATCH = 8'h58;
   localparam logic [7:0] CHAR_MATCH    = 8'h4D;
   localparam logic [7:0] CHAR_INSERT   = 8'h49;
   localparam logic [7:0] CHAR_DELETE   = 8'h44;
   localparam logic [7:0] CHAR_SOFT     = 8'h53;
   localparam logic [7:0] CHAR_HARD     = 8'h48;
   localparam logic [7:0] CHAR_SKIP     = 8'h4E;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_ACTIVE = 2'd1
   } phase_type;

   typedef enum logic [1:0] {
      KIND_OP    = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      OP_EQUAL    = 3'd0,
      OP_MISMATCH = 3'd1,
      OP_MATCH    = 3'd2,
      OP_INSERT   = 3'd3,
      OP_DELETE   = 3'd4,
      OP_SOFT     = 3'd5,
      OP_HARD     = 3'd6,
      OP_SKIP     = 3'd7
   } op_type_type;

   typedef enum logic [2:0] {
      ERR_DIGITS     = 3'd0,
      ERR_ZERO_COUNT = 3'd1,
      ERR_BAD_OP     = 3'd2,
      ERR_TOO_MANY   = 3'd3,
      ERR_EMPTY      = 3'd4
   } error_code_type;

   typedef struct packed {
      logic [7:0]         character;
      logic               first;
      logic signed [31:0] aligned_pos;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      op_type_type        op_type;
      logic [29:0]        op_length;
      logic signed [31:0] op_pos;
      logic [5:0]         op_index;
      logic [5:0]         n_ops;
      logic signed [31:0] final_pos;
      error_code_type     error_code;
   } rsp_type;

   typedef struct packed {
      logic    emit;
      rsp_type rsp;
   } step_type;

   typedef struct packed {
      logic        valid;
      op_type_type op;
      logic        advances;
   } op_decode_type;

   function automatic op_decode_type decode_op(input logic [7:0] c);
      op_decode_type d;
      d.valid    = 1'b1;
      d.advances = 1'b1;
      d.op       = OP_EQUAL;
      unique case (c)
         CHAR_EQUAL:    d.op = OP_EQUAL;
         CHAR_MISMATCH: d.op = OP_MISMATCH;
         CHAR_MATCH:    d.op = OP_MATCH;
         CHAR_INSERT: begin
            d.op       = OP_INSERT;
            d.advances = 1'b0;
         end
         CHAR_DELETE:   d.op = OP_DELETE;
         CHAR_SOFT: begin
            d.op       = OP_SOFT;
            d.advances = 1'b0;
         end
         CHAR_HARD: begin
            d.op       = OP_HARD;
            d.advances = 1'b0;
         end
         CHAR_SKIP:     d.op = OP_SKIP;
         default: begin
            d.valid    = 1'b0;
            d.advances = 1'b0;
         end
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

### design/csp_input_reg.sv
// Input register of the parser: holds one accepted request until the parse
// stage consumes it. Depends on csp_pkg.
`default_nettype none
module csp_input_reg
   import csp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire req_type req_data,
   output logic         req_stall,
   input  wire logic    advance,
   output logic         item_valid,
   output req_type      item
);

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;
   logic    accept;

   assign req_stall  = valid_ff && !advance;
   assign accept     = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item       = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

### design/csp_parse.sv
// Parse stage: the string state, the op count limit register and the
// per-character step logic. Depends on csp_pkg.
`default_nettype none
module csp_parse
   import csp_pkg::*;
#(
   parameter int MAX_DIGITS = CSP_MAX_DIGITS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [5:0] csr_wr_data,
   input  wire logic       step_en,
   input  wire req_type    item,
   output step_type        step
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  digits_ff, digits_in;
   logic [29:0] acc_ff, acc_in;
   logic [31:0] pos_ff, pos_in;
   logic [5:0]  ops_ff, ops_in;
   logic [5:0]  max_ops_ff;

   phase_type     phase_w;
   logic [3:0]    digits_w;
   logic [29:0]   acc_w;
   logic [31:0]   pos_w;
   logic [5:0]    ops_w;
   logic [29:0]   acc_ten;
   logic          is_digit;
   op_decode_type dec;

   assign acc_ten  = {acc_w[26:0], 3'b000} + {acc_w[28:0], 1'b0};
   assign is_digit = (item.character >= CHAR_ZERO) && (item.character <= CHAR_NINE);
   assign dec      = decode_op(item.character);

   always_comb begin
      phase_w  = phase_ff;
      digits_w = digits_ff;
      acc_w    = acc_ff;
      pos_w    = pos_ff;
      ops_w    = ops_ff;
      if (item.first) begin
         phase_w  = PHASE_ACTIVE;
         digits_w = '0;
         acc_w    = '0;
         pos_w    = item.aligned_pos;
         ops_w    = '0;
      end

      phase_in  = phase_w;
      digits_in = digits_w;
      acc_in    = acc_w;
      pos_in    = pos_w;
      ops_in    = ops_w;
      step      = '0;

      if (phase_w == PHASE_ACTIVE) begin
         if (digits_w == 4'd0 && acc_w == 30'd0 && ops_w >= max_ops_ff) begin
            step.emit           = 1'b1;
            step.rsp.kind       = KIND_ERROR;
            step.rsp.error_code = ERR_TOO_MANY;
            phase_in            = PHASE_IDLE;
         end else if (item.character == CHAR_NUL && digits_w == 4'd0) begin
            step.emit = 1'b1;
            phase_in  = PHASE_IDLE;
            if (ops_w == 6'd0) begin
               step.rsp.kind       = KIND_ERROR;
               step.rsp.error_code = ERR_EMPTY;
            end else begin
               step.rsp.kind      = KIND_DONE;
               step.rsp.n_ops     = ops_w;
               step.rsp.final_pos = pos_w;
            end
         end else if (is_digit) begin
            if (({1'b0, digits_w} + 5'd1) >= 5'(MAX_DIGITS)) begin
               step.emit           = 1'b1;
               step.rsp.kind       = KIND_ERROR;
               step.rsp.error_code = ERR_DIGITS;
               phase_in            = PHASE_IDLE;
            end else begin
               acc_in    = acc_ten + {26'd0, item.character[3:0]};
               digits_in = digits_w + 4'd1;
            end
         end else if (acc_w == 30'd0) begin
            step.emit           = 1'b1;
            step.rsp.kind       = KIND_ERROR;
            step.rsp.error_code = ERR_ZERO_COUNT;
            phase_in            = PHASE_IDLE;
         end else if (!dec.valid) begin
            step.emit           = 1'b1;
            step.rsp.kind       = KIND_ERROR;
            step.rsp.error_code = ERR_BAD_OP;
            phase_in            = PHASE_IDLE;
         end else if (({1'b0, ops_w} + 7'd1) >= {1'b0, max_ops_ff}) begin
            step.emit           = 1'b1;
            step.rsp.kind       = KIND_ERROR;
            step.rsp.error_code = ERR_TOO_MANY;
            phase_in            = PHASE_IDLE;
         end else begin
            step.emit          = 1'b1;
            step.rsp.kind      = KIND_OP;
            step.rsp.op_type   = dec.op;
            step.rsp.op_length = acc_w;
            step.rsp.op_pos    = pos_w;
            step.rsp.op_index  = ops_w;
            if (dec.advances) begin
               pos_in = pos_w + {2'b00, acc_w};
            end
            ops_in    = ops_w + 6'd1;
            digits_in = '0;
            acc_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_IDLE;
         digits_ff  <= '0;
         acc_ff     <= '0;
         pos_ff     <= '0;
         ops_ff     <= '0;
         max_ops_ff <= CSP_MAX_OPS_RESET;
      end else begin
         if (step_en) begin
            phase_ff  <= phase_in;
            digits_ff <= digits_in;
            acc_ff    <= acc_in;
            pos_ff    <= pos_in;
            ops_ff    <= ops_in;
         end
         if (csr_wr_en) begin
            max_ops_ff <= csr_wr_data;
         end
      end
   end

endmodule
`default_nettype wire

### design/csp_output_reg.sv
// Response register of the parser: holds one result until the receiver takes
// it and tells the parse stage when it may produce the next. Depends on csp_pkg.
`default_nettype none
module csp_output_reg
   import csp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step_en,
   input  wire step_type step,
   output logic          out_free,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  wire logic     rsp_stall
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign out_free  = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (step_en && step.emit) begin
         valid_in = 1'b1;
         data_in  = step.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

### design/cigar_string_parser_unit.sv
// Top level of the alignment op string parser.
// Depends on csp_pkg, csp_input_reg, csp_parse and csp_output_reg.
//
// Each request carries one character of an op string; a request with first
// set starts a new string and loads its start position. Digits build a count,
// and each op letter yields one op response with type, count, position and
// index. A zero character after an op ends the string with a done response, and
// every failure yields one error response, after which characters are ignored
// until the next first request. Many requests yield no response.
// The csr port writes the op count limit; write it only while the block is idle.
// A request is taken into the input register, and its response, if any, is
// written into the response register when the parse stage takes the request.
// One request is accepted every cycle while the receiver keeps up; the
// combinational parse step between the two registers sets that rate.
// When the receiver stalls, the response register holds and the input register
// fills, after which req_stall is raised until the response is taken.
// Synchronous reset empties both registers, returns the parser to idle with
// all counts and the position at zero, and sets the op limit to 50.
`default_nettype none
module cigar_string_parser_unit
   import csp_pkg::*;
#(
   parameter int MAX_DIGITS = CSP_MAX_DIGITS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire req_type    req_data,
   output logic            req_stall,
   output logic            rsp_valid,
   output rsp_type         rsp_data,
   input  wire logic       rsp_stall,
   input  wire logic       csr_wr_en,
   input  wire logic [5:0] csr_wr_data
);

   logic     item_valid;
   req_type  item;
   logic     out_free;
   logic     advance;
   step_type step;

   assign advance = item_valid && out_free;

   csp_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   csp_parse #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step_en     (advance),
      .item        (item),
      .step        (step)
   );

   csp_output_reg u_output_reg (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step      (step),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for cigar_string_parser_unit: a directed table, then random
// op strings under several op count limits, with random idling on both channels.
// Depends on csp_pkg and the cigar_string_parser_unit RTL.
`timescale 1ns / 100ps
module tb_top;
   import csp_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int ITEMS_PER_LIMIT = 190;
   localparam logic [7:0] CHAR_BAD = 8'h51;

   typedef struct packed {
      req_type req;
      logic    fixed;
      logic    emits;
      rsp_type rsp;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   req_type    req_data = '0;
   logic       req_stall;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       rsp_stall = 1'b0;
   logic       csr_wr_en = 1'b0;
   logic [5:0] csr_wr_data = '0;

   phase_type   parse_state = PHASE_IDLE;
   logic [3:0]  digits_held = '0;
   logic [29:0] count_held = '0;
   logic [31:0] position = '0;
   logic [5:0]  ops_done = '0;
   logic [5:0]  op_limit = CSP_MAX_OPS_RESET;

   rsp_type      parse_results_due[$];
   stim_row_type directed_rows[$];
   int unsigned  items_parsed = 0;
   int unsigned  fail_count = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  stall_left = 0;
   int unsigned  stall_len;
   bit           rsp_quiet = 1'b0;
   bit           sender_quiet = 1'b0;

   cigar_string_parser_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type error_result(input error_code_type code);
      rsp_type o;
      o = '0;
      o.kind = KIND_ERROR;
      o.error_code = code;
      return o;
   endfunction

   function automatic rsp_type op_result(input op_type_type op, input logic [29:0] len,
                                         input logic [31:0] pos, input logic [5:0] idx);
      rsp_type o;
      o = '0;
      o.kind = KIND_OP;
      o.op_type = op;
      o.op_length = len;
      o.op_pos = pos;
      o.op_index = idx;
      return o;
   endfunction

   function automatic bit parse_character(input req_type r, output rsp_type res);
      logic [63:0] wide;
      op_type_type op;
      bit known;
      bit moves;
      res = '0;
      known = 1'b1;
      moves = 1'b1;
      op = OP_EQUAL;
      if (r.first) begin
         parse_state = PHASE_ACTIVE;
         position = r.aligned_pos;
         digits_held = '0;
         count_held = '0;
         ops_done = '0;
      end
      if (parse_state != PHASE_ACTIVE) return 1'b0;

      if (digits_held == 0 && count_held == 0 && ops_done >= op_limit) begin
         res = error_result(ERR_TOO_MANY);
      end else if (r.character == CHAR_NUL && digits_held == 0) begin
         if (ops_done == 0) begin
            res = error_result(ERR_EMPTY);
         end else begin
            res.kind = KIND_DONE;
            res.n_ops = ops_done;
            res.final_pos = position;
         end
      end else if (r.character >= CHAR_ZERO && r.character <= CHAR_NINE) begin
         if (int'(digits_held) + 1 >= CSP_MAX_DIGITS) begin
            res = error_result(ERR_DIGITS);
         end else begin
            wide = {34'd0, count_held} * 64'd10 + {56'd0, r.character - CHAR_ZERO};
            count_held = wide[29:0];
            digits_held = digits_held + 4'd1;
            return 1'b0;
         end
      end else if (count_held == 0) begin
         res = error_result(ERR_ZERO_COUNT);
      end else begin
         case (r.character)
            CHAR_EQUAL:    op = OP_EQUAL;
            CHAR_MISMATCH: op = OP_MISMATCH;
            CHAR_MATCH:    op = OP_MATCH;
            CHAR_INSERT: begin
               op = OP_INSERT;
               moves = 1'b0;
            end
            CHAR_DELETE:   op = OP_DELETE;
            CHAR_SOFT: begin
               op = OP_SOFT;
               moves = 1'b0;
            end
            CHAR_HARD: begin
               op = OP_HARD;
               moves = 1'b0;
            end
            CHAR_SKIP:     op = OP_SKIP;
            default: begin
               known = 1'b0;
            end
         endcase
         if (!known) begin
            res = error_result(ERR_BAD_OP);
         end else if ({1'b0, ops_done} + 7'd1 >= {1'b0, op_limit}) begin
            res = error_result(ERR_TOO_MANY);
         end else begin
            res = op_result(op, count_held, position, ops_done);
            if (moves) position = position + {2'b00, count_held};
            ops_done = ops_done + 6'd1;
            digits_held = '0;
            count_held = '0;
            return 1'b1;
         end
      end
      // A done or an error ends the string.
      parse_state = PHASE_IDLE;
      return 1'b1;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic string describe(input rsp_type x);
      return $sformatf("kind %0d type %0d length %0d pos %h index %0d ops %0d final %h error %0d",
                       x.kind, x.op_type, x.op_length, x.op_pos, x.op_index, x.n_ops,
                       x.final_pos, x.error_code);
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   task automatic check_response(input rsp_type got);
      rsp_type want;
      if (parse_results_due.size() == 0) begin
         note_failure($sformatf("unexpected response: %s", describe(got)));
      end else begin
         want = parse_results_due.pop_front();
         if (got.kind !== want.kind || got.op_type !== want.op_type ||
             got.op_length !== want.op_length || got.op_pos !== want.op_pos ||
             got.op_index !== want.op_index || got.n_ops !== want.n_ops ||
             got.final_pos !== want.final_pos || got.error_code !== want.error_code) begin
            note_failure($sformatf("response mismatch\n  expected %s\n  actual   %s",
                                   describe(want), describe(got)));
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_response(rsp_data);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         if ($urandom_range(0, 199) == 0) rsp_quiet = !rsp_quiet;
         stall_len = rsp_quiet ? 0 : pick_gap();
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            stall_left = stall_len - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("cigar_string_parser_unit test failed");
      $finish;
   end

   task automatic send_request(input req_type r, input logic fixed, input logic fixed_emits,
                               input rsp_type fixed_rsp);
      rsp_type want;
      bit emits;
      int unsigned gap;
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_parsed++;
      emits = parse_character(r, want);
      if (fixed) begin
         if (fixed_emits) parse_results_due.push_back(fixed_rsp);
      end else if (emits) begin
         parse_results_due.push_back(want);
      end
      gap = sender_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic add_row(input logic [7:0] c, input logic first_flag, input logic [31:0] pos,
                          input logic fixed_flag, input logic emits_flag, input rsp_type want);
      stim_row_type row;
      row.req.character = c;
      row.req.first = first_flag;
      row.req.aligned_pos = pos;
      row.fixed = fixed_flag;
      row.emits = emits_flag;
      row.rsp = want;
      directed_rows.push_back(row);
   endtask

   task automatic put_char(input logic [7:0] c, input logic first_flag, input logic [31:0] pos);
      req_type r;
      int unsigned noise;
      noise = $urandom_range(0, 255);
      r.character = ($urandom_range(0, 59) == 0) ? noise[7:0] : c;
      r.first = first_flag;
      r.aligned_pos = pos;
      send_request(r, 1'b0, 1'b0, '0);
   endtask

   task automatic write_op_limit(input logic [5:0] value);
      req_valid <= 1'b0;
      while (parse_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      op_limit = value;
   endtask

   task automatic send_string();
      int unsigned n_ops_want, n_digits, k, d, dig, roll, noise;
      logic [31:0] start;
      logic [7:0] c;
      bit first_char;
      bit all_nines;
      if ($urandom_range(0, 7) == 0) sender_quiet = !sender_quiet;
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            noise = $urandom_range(0, 255);
            put_char(noise[7:0], 1'b0, $urandom);
         end
      end
      case ($urandom_range(0, 9))
         0: start = 32'h7FFF_FFFF;
         1: start = 32'h8000_0000;
         2: start = 32'hFFFF_FFF0;
         3: start = 32'h0000_0000;
         default: start = $urandom;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 70) n_ops_want = $urandom_range(0, 4);
      else if (roll < 92) n_ops_want = $urandom_range(5, 12);
      else n_ops_want = op_limit - 1 + $urandom_range(0, 1);
      first_char = 1'b1;
      for (k = 0; k < n_ops_want; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) n_digits = 0;
         else if (roll < 60) n_digits = $urandom_range(1, 2);
         else if (roll < 85) n_digits = $urandom_range(3, 5);
         else if (roll < 96) n_digits = 9;
         else n_digits = 10;
         all_nines = ($urandom_range(0, 2) == 0);
         for (d = 0; d < n_digits; d++) begin
            if (all_nines) dig = 9;
            else if (d == 0) dig = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
            else dig = $urandom_range(0, 9);
            put_char(CHAR_ZERO + dig[7:0], first_char, first_char ? start : $urandom);
            first_char = 1'b0;
         end
         case ($urandom_range(0, 7))
            0: c = CHAR_EQUAL;
            1: c = CHAR_MISMATCH;
            2: c = CHAR_MATCH;
            3: c = CHAR_INSERT;
            4: c = CHAR_DELETE;
            5: c = CHAR_SOFT;
            6: c = CHAR_HARD;
            default: c = CHAR_SKIP;
         endcase
         put_char(c, first_char, first_char ? start : $urandom);
         first_char = 1'b0;
      end
      if ($urandom_range(0, 19) != 0) put_char(CHAR_NUL, first_char, first_char ? start : $urandom);
   endtask

   initial begin
      req_type closing;
      logic [5:0] limit_value;
      int unsigned goal;
      int phase_no;

      add_row(CHAR_MATCH, 1'b0, 32'h0, 1'b1, 1'b0, '0);
      add_row(CHAR_NUL, 1'b1, 32'h8000_0000, 1'b1, 1'b1, error_result(ERR_EMPTY));
      add_row(CHAR_ZERO + 8'd1, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0, '0);
      add_row(CHAR_EQUAL, 1'b0, 32'h0, 1'b1, 1'b1,
              op_result(OP_EQUAL, 30'd1, 32'h7FFF_FFFF, 6'd0));
      add_row(CHAR_ZERO + 8'd2, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_MISMATCH, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_ZERO + 8'd3, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
      add_row(CHAR_MATCH, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_ZERO + 8'd4, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_INSERT, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_ZERO + 8'd5, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_DELETE, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_ZERO + 8'd6, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_SOFT, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_ZERO + 8'd7, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_HARD, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_ZERO + 8'd8, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_SKIP, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_NUL, 1'b0, 32'h0, 1'b0, 1'b0, '0);
      add_row(CHAR_ZERO, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);
      add_row(CHAR_MATCH, 1'b0, 32'h0, 1'b1, 1'b1, error_result(ERR_ZERO_COUNT));
      add_row(CHAR_ZERO + 8'd3, 1'b1, 32'h0, 1'b1, 1'b0, '0);
      add_row(CHAR_NUL, 1'b0, 32'h0, 1'b1, 1'b1, error_result(ERR_BAD_OP));
      add_row(8'hFF, 1'b1, 32'h0, 1'b1, 1'b1, error_result(ERR_ZERO_COUNT));
      add_row(CHAR_ZERO + 8'd7, 1'b1, 32'h0, 1'b1, 1'b0, '0);
      add_row(CHAR_BAD, 1'b0, 32'h0, 1'b1, 1'b1, error_result(ERR_BAD_OP));
      add_row(CHAR_SKIP, 1'b0, 32'h0, 1'b1, 1'b0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].emits,
                      directed_rows[i].rsp);
      end

      for (phase_no = 0; phase_no < 8; phase_no++) begin
         // An empty string leaves the parser idle before the limit changes.
         closing.character = CHAR_NUL;
         closing.first = 1'b1;
         closing.aligned_pos = $urandom;
         send_request(closing, 1'b0, 1'b0, '0);
         case (phase_no)
            0: limit_value = 6'd1;
            1: limit_value = 6'd63;
            2: limit_value = 6'd2;
            7: limit_value = CSP_MAX_OPS_RESET;
            default: limit_value = 6'($urandom_range(3, 63));
         endcase
         write_op_limit(limit_value);
         goal = items_parsed + ITEMS_PER_LIMIT;
         while (items_parsed < goal) send_string();
      end

      req_valid <= 1'b0;
      while (parse_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (parse_results_due.size() != 0) begin
         note_failure($sformatf("%0d expected responses never arrived",
                                parse_results_due.size()));
      end
      if (fail_count == 0) begin
         $display("cigar_string_parser_unit test passed");
      end else begin
         $display("cigar_string_parser_unit test failed");
      end
      $finish;
   end

endmodule
